// ===== rtl/mavg_pkg.sv =====
// shared types and constants for the moving average filter
package mavg_pkg;

	// width of the window register as seen on the configuration port
	localparam int CFG_W = 7;

	// window length after reset
	localparam int WINDOW_RESET = 5;

	// front end sequencer states
	typedef enum logic {
		FS_IDLE,
		FS_UPDATE
	} front_state_t;

	// back end divider states
	typedef enum logic [1:0] {
		BS_IDLE,
		BS_DIV,
		BS_DONE
	} back_state_t;

	// queue fill status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/mavg_ram.sv =====
// generic single-clock ram with one write port and one registered read port
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// storage array with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mavg_front.sv =====
// front end: accepts samples, keeps the sample history and the running sum
module mavg_front
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                    last_in_signal,
	input  q_status_t               q_stat,
	output logic                    push,
	output logic signed [SUM_W-1:0] push_sum,
	output logic [CNT_W-1:0]        push_div,
	output logic                    push_last
);

	localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int RST_WIN = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	front_state_t state_q, state_d;

	logic [CNT_W-1:0]              window_q;
	logic [CNT_W-1:0]              win_wr;
	logic [PTR_W-1:0]              wp_q;
	logic [PTR_W-1:0]              wp_next;
	logic [PTR_W-1:0]              old_addr;
	logic [CNT_W:0]                wp_ext;
	logic [CNT_W:0]                win_ext;
	logic [CNT_W:0]                old_ext;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SUM_W-1:0]       sum_next;
	logic [CNT_W-1:0]              seen_q;
	logic [CNT_W-1:0]              seen_next;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic                          accept;
	logic                          full_window;

	assign accept = sample_valid && !sample_stall;

	// clamp the written window length to one up to the ring depth
	always_comb begin
		if (cfg_wdata == '0) begin
			win_wr = CNT_W'(1);
		end else if ((CNT_W + CFG_W)'(cfg_wdata) > (CNT_W + CFG_W)'(MAX_WINDOW)) begin
			win_wr = CNT_W'(MAX_WINDOW);
		end else begin
			win_wr = CNT_W'(cfg_wdata);
		end
	end

	// slot of the sample that drops out of the window
	always_comb begin
		wp_ext  = (CNT_W + 1)'(wp_q);
		win_ext = (CNT_W + 1)'(window_q);
		if (wp_ext >= win_ext) begin
			old_ext = wp_ext - win_ext;
		end else begin
			old_ext = wp_ext + (CNT_W + 1)'(MAX_WINDOW) - win_ext;
		end
		old_addr = old_ext[PTR_W-1:0];
	end

	assign wp_next = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);

	// running sum update, the oldest sample leaves once the window is full
	always_comb begin
		full_window = (seen_q >= window_q);
		if (full_window) begin
			sum_next  = sum_q + SUM_W'(sample_q) - SUM_W'($signed(ram_rdata));
			seen_next = seen_q;
		end else begin
			sum_next  = sum_q + SUM_W'(sample_q);
			seen_next = seen_q + CNT_W'(1);
		end
	end

	// sample history ring
	mavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == FS_UPDATE),
		.waddr (wp_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (old_addr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (accept) begin
					state_d = FS_UPDATE;
				end
			end
			FS_UPDATE: begin
				state_d = FS_IDLE;
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	// handshake and queue outputs
	always_comb begin
		sample_stall = (state_q != FS_IDLE) || q_stat.full;
		push         = (state_q == FS_UPDATE);
		push_sum     = sum_next;
		push_div     = seen_next;
		push_last    = last_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FS_IDLE;
			window_q <= CNT_W'(RST_WIN);
			wp_q     <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_q <= win_wr;
				wp_q     <= '0;
				sum_q    <= '0;
				seen_q   <= '0;
			end else if (state_q == FS_UPDATE) begin
				if (last_q) begin
					wp_q   <= '0;
					sum_q  <= '0;
					seen_q <= '0;
				end else begin
					wp_q   <= wp_next;
					sum_q  <= sum_next;
					seen_q <= seen_next;
				end
			end
		end
	end

	// captured request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			last_q   <= last_in_signal;
		end
	end

`ifndef SYNTH
	a_seen_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= window_q)
		else $error("sample count beyond window length");
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == FS_UPDATE) && push)
		else $error("accepted request not pushed in the next cycle");
`endif

endmodule

// ===== rtl/mavg_queue.sv =====
// two-entry queue between the front end and the divider
module mavg_queue
	import mavg_pkg::*;
#(
	parameter int WIDTH = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_status_t        stat
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	assign pop_data   = entry_q[rd_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/mavg_back.sv =====
// back end: divides the window sum by its length and holds the result
module mavg_back
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_status_t               q_stat,
	output logic                    pop,
	input  logic signed [SUM_W-1:0] pop_sum,
	input  logic [CNT_W-1:0]        pop_div,
	input  logic                    pop_last,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                    last_out,
	output logic                    average_valid,
	input  logic                    average_stall
);

	localparam int STEP_W = $clog2(SUM_W);

	back_state_t state_q, state_d;

	logic [SUM_W-1:0]       dvd_q;
	logic [SUM_W-1:0]       dvd_next;
	logic [SUM_W-1:0]       mag_in;
	logic [SUM_W-1:0]       quot_signed;
	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W-1:0]       rem_next;
	logic [CNT_W:0]         trial;
	logic                   ge;
	logic [CNT_W-1:0]       div_q;
	logic                   neg_q;
	logic                   last_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS-1:0] avg_q;

	// magnitude of the incoming sum
	assign mag_in = pop_sum[SUM_W-1] ? (~pop_sum + SUM_W'(1)) : pop_sum;

	// one restoring division step, quotient bits shift in from the bottom
	always_comb begin
		trial       = {rem_q, dvd_q[SUM_W-1]};
		ge          = (trial >= {1'b0, div_q});
		rem_next    = ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		dvd_next    = {dvd_q[SUM_W-2:0], ge};
		quot_signed = neg_q ? (~dvd_next + SUM_W'(1)) : dvd_next;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!q_stat.empty) begin
					state_d = BS_DIV;
				end
			end
			BS_DIV: begin
				if (step_q == '0) begin
					state_d = BS_DONE;
				end
			end
			BS_DONE: begin
				if (!average_stall) begin
					state_d = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	// queue and result handshake
	always_comb begin
		pop           = (state_q == BS_IDLE) && !q_stat.empty;
		average_valid = (state_q == BS_DONE);
		average       = avg_q;
		last_out      = last_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= STEP_W'(SUM_W - 1);
			end else if (state_q == BS_DIV) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// divider datapath and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q  <= mag_in;
			rem_q  <= '0;
			div_q  <= pop_div;
			neg_q  <= pop_sum[SUM_W-1];
			last_q <= pop_last;
		end else if (state_q == BS_DIV) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
			if (step_q == '0) begin
				avg_q <= quot_signed[SAMPLE_BITS-1:0];
			end
		end
	end

`ifndef SYNTH
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_div != '0)
		else $error("zero window length reached the divider");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_DIV) && (step_q == '0) |=> average_valid)
		else $error("result not presented after the last division step");
`endif

endmodule

// ===== rtl/moving_average_filter.sv =====
// top level of the moving average filter
//
// Samples arrive on the sample channel (sample_valid, sample_stall, sample,
// last_in_signal); one average leaves on the average channel (average_valid,
// average_stall, average, last_out) for every sample taken. A request moves
// on a rising edge with valid high and stall low.
// cfg_we with cfg_wdata sets the window length (0 reads as 1, values above
// MAX_WINDOW saturate) and clears the history; write it only while idle.
// A sample marked last_in_signal ends the signal and clears the history
// after its own average.
// The front end handles each sample as a ring read followed by a sum update,
// takes no new sample until both are done, and feeds a two-entry queue. The
// back end divides bit-serially, one quotient bit per cycle, and pops the
// next request only after its result has been taken, which sets the
// sustained rate. Reset sets the window to 5 (capped at MAX_WINDOW) and
// empties history, queue and divider; the ring itself is not cleared and
// needs no clearing pass.
// While average_stall is high the result holds and the queue fills; the
// front end stalls once both queue entries are in use.
module moving_average_filter
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_W-1:0]              cfg_wdata,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_in_signal,
	output logic                          average_valid,
	input  logic                          average_stall,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          last_out
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int Q_W   = SUM_W + CNT_W + 1;

	q_status_t               q_stat;
	logic                    push;
	logic signed [SUM_W-1:0] push_sum;
	logic [CNT_W-1:0]        push_div;
	logic                    push_last;
	logic                    pop;
	logic [Q_W-1:0]          pop_data;

	// sample intake and running sum
	mavg_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.last_in_signal (last_in_signal),
		.q_stat         (q_stat),
		.push           (push),
		.push_sum       (push_sum),
		.push_div       (push_div),
		.push_last      (push_last)
	);

	// decoupling queue
	mavg_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sum, push_div, push_last}),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// divider and result register
	mavg_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop           (pop),
		.pop_sum       ($signed(pop_data[Q_W-1 -: SUM_W])),
		.pop_div       (pop_data[CNT_W:1]),
		.pop_last      (pop_data[0]),
		.average       (average),
		.last_out      (last_out),
		.average_valid (average_valid),
		.average_stall (average_stall)
	);

endmodule
